// ===== design/particle_grid_deposit_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the particle grid deposit block
// Shared clocked assertion forms, used one per line by the checker.
// ----------------------------------------------------------------------------
`ifndef PARTICLE_GRID_DEPOSIT_TOP_DEFINES_SVH
`define PARTICLE_GRID_DEPOSIT_TOP_DEFINES_SVH

// implication checked on every rising edge outside reset
`define PGD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked on every rising edge outside reset
`define PGD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/pgd_pkg.sv =====
// ----------------------------------------------------------------------------
// pgd_pkg
// Types and constants of the particle grid deposit block.
// ----------------------------------------------------------------------------
package pgd_pkg;

    typedef logic signed [31:0] t_q16;
    typedef logic signed [63:0] t_acc;
    typedef logic [31:0]        t_cnt;
    typedef logic [23:0]        t_scale;
    typedef logic [1:0]         t_status;
    typedef logic [2:0]         t_cfg_idx;

    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_OUTSIDE = 2'd1;
    localparam t_status ST_ZMASS   = 2'd2;

    localparam t_cfg_idx CFG_X_LOW   = 3'd0;
    localparam t_cfg_idx CFG_Y_LOW   = 3'd1;
    localparam t_cfg_idx CFG_Z_LOW   = 3'd2;
    localparam t_cfg_idx CFG_X_SCALE = 3'd3;
    localparam t_cfg_idx CFG_Y_SCALE = 3'd4;
    localparam t_cfg_idx CFG_Z_SCALE = 3'd5;

    localparam logic [31:0] RST_X_LOW   = 32'd11796480;
    localparam logic [31:0] RST_YZ_LOW  = 32'd2621440;
    localparam t_scale      RST_X_SCALE = 24'd52429;
    localparam t_scale      RST_YZ_SCALE = 24'd13107;

    localparam t_cnt CNT_MAX = 32'hFFFF_FFFF;
    localparam t_acc ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam t_acc ACC_MIN = 64'sh8000_0000_0000_0000;

    // saturating 64-bit signed add
    function automatic t_acc sat_add(input t_acc a, input t_acc b);
        t_acc r;
        r = a + b;
        if ((a[63] == b[63]) && (r[63] != a[63])) begin
            r = a[63] ? ACC_MIN : ACC_MAX;
        end
        return r;
    endfunction

    function automatic t_cnt sat_inc(input t_cnt a);
        return (a == CNT_MAX) ? a : a + 32'd1;
    endfunction

endpackage

// ===== design/pgd_div.sv =====
// ----------------------------------------------------------------------------
// pgd_div
// Sequential signed divider, one quotient bit per cycle, truncating to zero.
// ----------------------------------------------------------------------------
module pgd_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  pgd_pkg::t_acc      i_num,
    input  pgd_pkg::t_q16      i_den,
    output logic               o_done,
    output pgd_pkg::t_acc      o_quo
);
    import pgd_pkg::*;

    logic [63:0] r_quo, n_quo;
    logic [32:0] r_rem, n_rem;
    logic [31:0] r_den;
    logic        r_neg;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [33:0] w_trial;
    logic [63:0] w_mag;

    assign w_mag   = i_num[63] ? 64'(-i_num) : i_num;
    assign w_trial = {r_rem, r_quo[63]} - {2'b00, r_den};

    // restoring step
    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        if (!w_trial[33]) begin
            n_rem = w_trial[32:0];
            n_quo = {r_quo[62:0], 1'b1};
        end else begin
            n_rem = {r_rem[31:0], r_quo[63]};
            n_quo = {r_quo[62:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd64;
                r_quo  <= w_mag;
                r_rem  <= '0;
                r_den  <= i_den[31] ? 32'(-i_den) : i_den;
                r_neg  <= i_num[63] ^ i_den[31];
            end else if (r_busy) begin
                r_quo <= n_quo;
                r_rem <= n_rem;
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_neg ? 64'(-r_quo) : r_quo;
endmodule

// ===== design/particle_grid_deposit_top.sv =====
// ----------------------------------------------------------------------------
// particle_grid_deposit_top
// Nearest-grid-point deposition of particles into a per-cell memory.
// ----------------------------------------------------------------------------
// One item at a time. After reset the cell memory is swept to zero, one cell
// per cycle, before the first item is taken. A read of a cell in range passes
// through the states S_RD and S_RDAT to S_OUT before its result is shown. A
// deposit in the grid with nonzero mass passes through S_MUL, S_CHK, S_DIV,
// S_RD and S_RMW to S_OUT. In S_DIV the bit-serial divider forms the three
// current terms: one per axis, one division each, all three running in
// parallel. S_RMW is the read-modify-write of the cell. The next beat is
// taken in the cycle after the result beat leaves.
module particle_grid_deposit_top #(
    parameter int GRID_X = 32,
    parameter int GRID_Y = 32,
    parameter int GRID_Z = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  pgd_pkg::t_cfg_idx   i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_cmd,
    input  pgd_pkg::t_q16       i_pos_x,
    input  pgd_pkg::t_q16       i_pos_y,
    input  pgd_pkg::t_q16       i_pos_z,
    input  pgd_pkg::t_q16       i_vel_x,
    input  pgd_pkg::t_q16       i_vel_y,
    input  pgd_pkg::t_q16       i_vel_z,
    input  pgd_pkg::t_q16       i_charge,
    input  pgd_pkg::t_q16       i_mass,
    input  logic [14:0]         i_cell_index,
    output logic                o_valid,
    input  logic                i_ready,
    output pgd_pkg::t_status    o_status,
    output pgd_pkg::t_cnt       o_total_count,
    output pgd_pkg::t_cnt       o_ion_count,
    output pgd_pkg::t_cnt       o_electron_count,
    output pgd_pkg::t_acc       o_current_x,
    output pgd_pkg::t_acc       o_current_y,
    output pgd_pkg::t_acc       o_current_z
);
    import pgd_pkg::*;

    localparam int NCELLS = GRID_X * GRID_Y * GRID_Z;
    localparam int AW     = $clog2(NCELLS);
    localparam int XW     = $clog2(GRID_X);
    localparam int YW     = $clog2(GRID_Y);
    localparam int ZW     = $clog2(GRID_Z);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_MUL  = 4'd2;
    localparam logic [3:0] S_CHK  = 4'd3;
    localparam logic [3:0] S_DIV  = 4'd4;
    localparam logic [3:0] S_RD   = 4'd5;
    localparam logic [3:0] S_RMW  = 4'd6;
    localparam logic [3:0] S_OUT  = 4'd7;
    localparam logic [3:0] S_RDAT = 4'd8;

    typedef struct packed {
        t_cnt total;
        t_cnt ions;
        t_cnt elec;
        t_acc cx;
        t_acc cy;
        t_acc cz;
    } t_cell;

    t_cell r_mem [NCELLS];
    t_cell r_rdata;

    logic [3:0]  r_state;
    logic [AW:0] r_clr;
    logic [31:0] r_x_low, r_y_low, r_z_low;
    t_scale      r_x_scale, r_y_scale, r_z_scale;

    logic        r_cmd;
    t_q16        r_pos [3];
    t_q16        r_vel [3];
    t_q16        r_q, r_m;
    logic signed [57:0] r_prod [3];
    logic [AW-1:0] r_addr;
    t_acc        r_term [3];

    logic        r_ovalid;
    t_status     r_status;
    t_cell       r_odata;

    logic        w_start;
    logic [2:0]  w_done;
    t_acc        w_quo [3];
    logic        w_we;
    t_cell       w_wdata;
    logic        w_in_x, w_in_y, w_in_z;
    logic [AW-1:0] w_lin;
    logic [31:0] w_low [3];
    t_scale      w_scl [3];

    assign w_low = '{r_x_low, r_y_low, r_z_low};
    assign w_scl = '{r_x_scale, r_y_scale, r_z_scale};

    // axis range checks on registered products
    assign w_in_x = !r_prod[0][57] && (r_prod[0][57:32] < 26'(GRID_X));
    assign w_in_y = !r_prod[1][57] && (r_prod[1][57:32] < 26'(GRID_Y));
    assign w_in_z = !r_prod[2][57] && (r_prod[2][57:32] < 26'(GRID_Z));
    assign w_lin  = AW'((32'(r_prod[2][32+ZW-1:32]) * 32'(GRID_Y)
                      + 32'(r_prod[1][32+YW-1:32])) * 32'(GRID_X)
                      + 32'(r_prod[0][32+XW-1:32]));

    assign o_ready = (r_state == S_IDLE) && !r_ovalid;
    assign w_start = (r_state == S_CHK) && w_in_x && w_in_y && w_in_z && (r_m != '0);

    // three dividers for the current terms
    for (genvar g = 0; g < 3; g++) begin : g_div
        pgd_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (w_start),
            .i_num   (64'(r_vel[g]) * 64'(r_q)),
            .i_den   (r_m),
            .o_done  (w_done[g]),
            .o_quo   (w_quo[g])
        );
    end

    // updated cell value
    always_comb begin
        w_wdata       = '0;
        w_we          = 1'b0;
        if (r_state == S_CLR) begin
            w_we = 1'b1;
        end else if (r_state == S_RMW) begin
            w_we          = 1'b1;
            w_wdata.total = sat_inc(r_rdata.total);
            w_wdata.ions  = (r_q > 0) ? sat_inc(r_rdata.ions) : r_rdata.ions;
            w_wdata.elec  = (r_q > 0) ? r_rdata.elec : sat_inc(r_rdata.elec);
            w_wdata.cx    = sat_add(r_rdata.cx, r_term[0]);
            w_wdata.cy    = sat_add(r_rdata.cy, r_term[1]);
            w_wdata.cz    = sat_add(r_rdata.cz, r_term[2]);
        end
    end

    // cell memory, one port, registered read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[(r_state == S_CLR) ? r_clr[AW-1:0] : r_addr] <= w_wdata;
        end
        r_rdata <= r_mem[r_addr];
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_low   <= RST_X_LOW;
            r_y_low   <= RST_YZ_LOW;
            r_z_low   <= RST_YZ_LOW;
            r_x_scale <= RST_X_SCALE;
            r_y_scale <= RST_YZ_SCALE;
            r_z_scale <= RST_YZ_SCALE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_X_LOW:   r_x_low   <= i_cfg_data;
                CFG_Y_LOW:   r_y_low   <= i_cfg_data;
                CFG_Z_LOW:   r_z_low   <= i_cfg_data;
                CFG_X_SCALE: r_x_scale <= i_cfg_data[23:0];
                CFG_Y_SCALE: r_y_scale <= i_cfg_data[23:0];
                CFG_Z_SCALE: r_z_scale <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (AW+1)'(NCELLS - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_cmd  <= i_cmd;
                        r_pos  <= '{i_pos_x, i_pos_y, i_pos_z};
                        r_vel  <= '{i_vel_x, i_vel_y, i_vel_z};
                        r_q    <= i_charge;
                        r_m    <= i_mass;
                        r_addr <= AW'(i_cell_index);
                        if (i_cmd) begin
                            if (32'(i_cell_index) >= 32'(NCELLS)) begin
                                r_status <= ST_OUTSIDE;
                                r_odata  <= '0;
                                r_state  <= S_OUT;
                            end else begin
                                r_state <= S_RD;
                            end
                        end else begin
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    for (int a = 0; a < 3; a++) begin
                        r_prod[a] <= 58'(($signed({r_pos[a][31], r_pos[a]})
                                     - $signed({w_low[a][31], w_low[a]}))
                                     * $signed({1'b0, w_scl[a]}));
                    end
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    r_odata <= '0;
                    r_addr  <= w_lin;
                    if (!(w_in_x && w_in_y && w_in_z)) begin
                        r_status <= ST_OUTSIDE;
                        r_state  <= S_OUT;
                    end else if (r_m == '0) begin
                        r_status <= ST_ZMASS;
                        r_state  <= S_OUT;
                    end else begin
                        r_status <= ST_OK;
                        r_state  <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (&w_done) begin
                        r_term  <= w_quo;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= r_cmd ? S_RDAT : S_RMW;
                end
                S_RMW: begin
                    r_state <= S_OUT;
                end
                S_RDAT: begin
                    r_status <= ST_OK;
                    r_odata  <= r_rdata;
                    r_state  <= S_OUT;
                end
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid          = r_ovalid;
    assign o_status         = r_status;
    assign o_total_count    = r_odata.total;
    assign o_ion_count      = r_odata.ions;
    assign o_electron_count = r_odata.elec;
    assign o_current_x      = r_odata.cx;
    assign o_current_y      = r_odata.cy;
    assign o_current_z      = r_odata.cz;
endmodule

// ===== design/pgd_checker.sv =====
// ----------------------------------------------------------------------------
// pgd_checker
// Port-level checks on the particle grid deposit block.
// ----------------------------------------------------------------------------
`include "particle_grid_deposit_top_defines.svh"

module pgd_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_ready,
    input logic                o_valid,
    input logic                i_ready,
    input pgd_pkg::t_status    o_status,
    input pgd_pkg::t_cnt       o_total_count,
    input pgd_pkg::t_cnt       o_ion_count,
    input pgd_pkg::t_cnt       o_electron_count
);
    import pgd_pkg::*;

    // one item in flight: no new beat while a result waits
    `PGD_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, o_valid, !o_ready, "accept while result pending")
    // a beat in is not answered in the very next cycle
    `PGD_ASSERT_NXT(a_no_instant, i_clk, i_rst_n, i_valid && o_ready, !o_valid, "result too early")
    // status never takes an unused code
    `PGD_ASSERT_IMP(a_status_code, i_clk, i_rst_n, o_valid, o_status != 2'd3, "bad status code")
    // ion and electron counts never exceed the total
    `PGD_ASSERT_IMP(a_split, i_clk, i_rst_n, o_valid && o_status == ST_OK, o_ion_count <= o_total_count && o_electron_count <= o_total_count, "count split")
endmodule

bind particle_grid_deposit_top pgd_checker u_pgd_checker (.*);

// ===== tb/particle_grid_deposit_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// particle_grid_deposit_checker
// Watches the configuration port and both channels of the deposit block. It
// keeps its own copy of the cell store and the grid registers, works out the
// result of every accepted beat, and compares each output beat with the
// oldest expected result.
// ----------------------------------------------------------------------------
module particle_grid_deposit_checker #(
    parameter int GRID_X = 32,
    parameter int GRID_Y = 32,
    parameter int GRID_Z = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  pgd_pkg::t_cfg_idx   i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    input  logic                i_valid,
    input  logic                i_ready_in,
    input  logic                i_cmd,
    input  pgd_pkg::t_q16       i_pos_x,
    input  pgd_pkg::t_q16       i_pos_y,
    input  pgd_pkg::t_q16       i_pos_z,
    input  pgd_pkg::t_q16       i_vel_x,
    input  pgd_pkg::t_q16       i_vel_y,
    input  pgd_pkg::t_q16       i_vel_z,
    input  pgd_pkg::t_q16       i_charge,
    input  pgd_pkg::t_q16       i_mass,
    input  logic [14:0]         i_cell_index,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  pgd_pkg::t_status    i_status,
    input  pgd_pkg::t_cnt       i_total_count,
    input  pgd_pkg::t_cnt       i_ion_count,
    input  pgd_pkg::t_cnt       i_electron_count,
    input  pgd_pkg::t_acc       i_current_x,
    input  pgd_pkg::t_acc       i_current_y,
    input  pgd_pkg::t_acc       i_current_z,
    output int                  o_errors,
    output int                  o_pending
);
    import pgd_pkg::*;

    localparam int NCELLS = GRID_X * GRID_Y * GRID_Z;

    typedef struct packed {
        t_status st;
        t_cnt    total;
        t_cnt    ions;
        t_cnt    electrons;
        t_acc    cx;
        t_acc    cy;
        t_acc    cz;
    } t_cell_result;

    // shadow grid registers
    logic signed [31:0] lo_x, lo_y, lo_z;
    logic [23:0]        sc_x, sc_y, sc_z;

    // shadow cell store
    t_cnt tot_mem [NCELLS];
    t_cnt ion_mem [NCELLS];
    t_cnt ele_mem [NCELLS];
    t_acc cx_mem  [NCELLS];
    t_acc cy_mem  [NCELLS];
    t_acc cz_mem  [NCELLS];

    t_cell_result cell_results_due[$];
    int           errors;

    assign o_errors  = errors;
    assign o_pending = cell_results_due.size();

    function automatic t_cnt sat_count(t_cnt a);
        return (a == '1) ? a : a + 1;
    endfunction

    function automatic t_acc sat_sum(t_acc a, t_acc b);
        t_acc s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63]) s = a[63] ? ACC_MIN : ACC_MAX;
        return s;
    endfunction

    // floor((pos - low) * scale); returns -1 when off this axis
    function automatic int axis_bin(logic signed [31:0] p, logic signed [31:0] lo,
                                    logic [23:0] sc, int n);
        logic signed [32:0] d;
        logic signed [63:0] prod;
        logic [31:0]        c;
        d = 33'(p) - 33'(lo);
        prod = 64'(d) * $signed({40'd0, sc});
        c = prod[63:32];
        if (prod < 0 || c >= n) return -1;
        return int'(c);
    endfunction

    // velocity*charge/mass, truncated toward zero
    function automatic t_acc current_term(logic signed [31:0] v, logic signed [31:0] q,
                                          logic signed [31:0] m);
        logic signed [63:0] num;
        num = 64'(v) * 64'(q);
        return num / 64'(m);
    endfunction

    function automatic t_cell_result deposit_or_read();
        t_cell_result r;
        int ix, iy, iz, ind;
        r = '0;
        if (i_cmd) begin
            if (i_cell_index >= NCELLS) begin
                r.st = ST_OUTSIDE;
            end else begin
                r.total = tot_mem[i_cell_index];
                r.ions = ion_mem[i_cell_index];
                r.electrons = ele_mem[i_cell_index];
                r.cx = cx_mem[i_cell_index];
                r.cy = cy_mem[i_cell_index];
                r.cz = cz_mem[i_cell_index];
            end
            return r;
        end
        ix = axis_bin(i_pos_x, lo_x, sc_x, GRID_X);
        iy = axis_bin(i_pos_y, lo_y, sc_y, GRID_Y);
        iz = axis_bin(i_pos_z, lo_z, sc_z, GRID_Z);
        if (ix < 0 || iy < 0 || iz < 0) begin
            r.st = ST_OUTSIDE;
        end else if (i_mass == 0) begin
            r.st = ST_ZMASS;
        end else begin
            ind = (iz * GRID_Y + iy) * GRID_X + ix;
            tot_mem[ind] = sat_count(tot_mem[ind]);
            if (i_charge > 0) ion_mem[ind] = sat_count(ion_mem[ind]);
            else ele_mem[ind] = sat_count(ele_mem[ind]);
            cx_mem[ind] = sat_sum(cx_mem[ind], current_term(i_vel_x, i_charge, i_mass));
            cy_mem[ind] = sat_sum(cy_mem[ind], current_term(i_vel_y, i_charge, i_mass));
            cz_mem[ind] = sat_sum(cz_mem[ind], current_term(i_vel_z, i_charge, i_mass));
            r.st = ST_OK;
        end
        return r;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t: %s got %0h expected %0h", $realtime, what, got, want);
        errors++;
    endtask

    initial errors = 0;

    always @(posedge i_clk) begin
        t_cell_result w;
        if (!i_rst_n) begin
            lo_x <= RST_X_LOW;
            lo_y <= RST_YZ_LOW;
            lo_z <= RST_YZ_LOW;
            sc_x <= RST_X_SCALE;
            sc_y <= RST_YZ_SCALE;
            sc_z <= RST_YZ_SCALE;
            for (int k = 0; k < NCELLS; k++) begin
                tot_mem[k] = '0; ion_mem[k] = '0; ele_mem[k] = '0;
                cx_mem[k] = '0; cy_mem[k] = '0; cz_mem[k] = '0;
            end
            cell_results_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_X_LOW:   lo_x <= i_cfg_data;
                    CFG_Y_LOW:   lo_y <= i_cfg_data;
                    CFG_Z_LOW:   lo_z <= i_cfg_data;
                    CFG_X_SCALE: sc_x <= i_cfg_data[23:0];
                    CFG_Y_SCALE: sc_y <= i_cfg_data[23:0];
                    CFG_Z_SCALE: sc_z <= i_cfg_data[23:0];
                    default: ;
                endcase
            end
            if (i_valid && i_ready_in) cell_results_due.push_back(deposit_or_read());
            if (i_out_valid && i_out_ready) begin
                if (cell_results_due.size() == 0) begin
                    report("unexpected beat", i_status, 0);
                end else begin
                    w = cell_results_due.pop_front();
                    if (i_status !== w.st) report("status", i_status, w.st);
                    if (i_total_count !== w.total) report("total", i_total_count, w.total);
                    if (i_ion_count !== w.ions) report("ions", i_ion_count, w.ions);
                    if (i_electron_count !== w.electrons)
                        report("electrons", i_electron_count, w.electrons);
                    if (i_current_x !== w.cx) report("current_x", i_current_x, w.cx);
                    if (i_current_y !== w.cy) report("current_y", i_current_y, w.cy);
                    if (i_current_z !== w.cz) report("current_z", i_current_z, w.cz);
                end
            end
        end
    end

endmodule

// ===== tb/particle_grid_deposit_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// particle_grid_deposit_top_test
// Drives deposit and read beats into the deposit block through several grid
// settings, with random gaps on both channels and one long output stall.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module particle_grid_deposit_top_test;
    import pgd_pkg::*;

    localparam logic CMD_DEPOSIT = 1'b0;
    localparam logic CMD_READ    = 1'b1;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        cfg_we = 0;
    t_cfg_idx    cfg_index = CFG_X_LOW;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 0;
    logic        in_ready;
    logic        cmd = CMD_DEPOSIT;
    t_q16        pos_x = 0, pos_y = 0, pos_z = 0;
    t_q16        vel_x = 0, vel_y = 0, vel_z = 0;
    t_q16        charge = 0, mass = 0;
    logic [14:0] cell_index = '0;
    logic        out_valid;
    logic        out_ready = 0;
    t_status     status;
    t_cnt        total_count, ion_count, electron_count;
    t_acc        current_x, current_y, current_z;
    int          errors, pending;
    bit          hold_off = 0;
    bit          stim_done = 0;

    // current grid, mirrored here to aim positions at cells
    logic signed [31:0] g_lo [3];
    logic [23:0]        g_sc [3];

    always #5 i_clk = ~i_clk;

    particle_grid_deposit_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .o_ready(in_ready), .i_cmd(cmd),
        .i_pos_x(pos_x), .i_pos_y(pos_y), .i_pos_z(pos_z),
        .i_vel_x(vel_x), .i_vel_y(vel_y), .i_vel_z(vel_z),
        .i_charge(charge), .i_mass(mass), .i_cell_index(cell_index),
        .o_valid(out_valid), .i_ready(out_ready), .o_status(status),
        .o_total_count(total_count), .o_ion_count(ion_count),
        .o_electron_count(electron_count),
        .o_current_x(current_x), .o_current_y(current_y), .o_current_z(current_z)
    );

    particle_grid_deposit_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .i_ready_in(in_ready), .i_cmd(cmd),
        .i_pos_x(pos_x), .i_pos_y(pos_y), .i_pos_z(pos_z),
        .i_vel_x(vel_x), .i_vel_y(vel_y), .i_vel_z(vel_z),
        .i_charge(charge), .i_mass(mass), .i_cell_index(cell_index),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_status(status),
        .i_total_count(total_count), .i_ion_count(ion_count),
        .i_electron_count(electron_count),
        .i_current_x(current_x), .i_current_y(current_y), .i_current_z(current_z),
        .o_errors(errors), .o_pending(pending)
    );

    // receiver: random ready gaps, plus a long hold-off when asked
    initial begin
        int gap;
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                out_ready <= 0;
                repeat (400) @(posedge i_clk);
                hold_off = 0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
            out_ready <= 0;
            repeat (gap) @(posedge i_clk);
            out_ready <= 1;
            while (!(out_valid && out_ready)) @(posedge i_clk);
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [31:0] val);
        cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 0;
        if (idx <= CFG_Z_LOW) g_lo[idx] = val;
        else if (idx <= CFG_Z_SCALE) g_sc[idx - CFG_X_SCALE] = val[23:0];
    endtask

    task automatic send_beat(logic c, t_q16 px, t_q16 py, t_q16 pz, t_q16 vx, t_q16 vy,
                             t_q16 vz, t_q16 q, t_q16 m, logic [14:0] ci, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 4);
        repeat (gap) @(posedge i_clk);
        in_valid <= 1; cmd <= c; pos_x <= px; pos_y <= py; pos_z <= pz;
        vel_x <= vx; vel_y <= vy; vel_z <= vz; charge <= q; mass <= m;
        cell_index <= ci;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        in_valid <= 0;
    endtask

    // position that lands in cell k of an axis, given the grid (scale nonzero)
    function automatic t_q16 pos_for(int ax, int k);
        logic signed [63:0] p;
        p = 64'(g_lo[ax]) + ((64'(k) << 32) + (64'(g_sc[ax]) >> 1)) / 64'(g_sc[ax]);
        return p[31:0];
    endfunction

    task automatic read_cell(logic [14:0] ci, bit no_gap);
        send_beat(CMD_READ, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, ci, no_gap);
    endtask

    task automatic drain();
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    // mostly in-grid deposits with random content, some reads and noise
    task automatic random_phase(int n, int span);
        int kx, ky, kz, sel;
        t_q16 m;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(0, 9);
            kx = $urandom_range(0, span); ky = $urandom_range(0, span);
            kz = $urandom_range(0, span);
            if (sel < 3) begin
                read_cell(15'((kz * 32 + ky) * 32 + kx), 0);
            end else if (sel == 3) begin
                send_beat(CMD_DEPOSIT, $urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom, 15'($urandom), 0);
            end else begin
                m = ($urandom_range(0, 15) == 0) ? 0 : $urandom;
                if ($urandom_range(0, 1)) m = $urandom_range(1, 70000);
                send_beat(CMD_DEPOSIT, pos_for(0, kx), pos_for(1, ky), pos_for(2, kz),
                          $urandom, $urandom, $urandom, $urandom, m, 15'($urandom), 0);
            end
        end
    endtask

    initial begin
        g_lo[0] = RST_X_LOW; g_lo[1] = RST_YZ_LOW; g_lo[2] = RST_YZ_LOW;
        g_sc[0] = RST_X_SCALE; g_sc[1] = RST_YZ_SCALE; g_sc[2] = RST_YZ_SCALE;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: reset grid, corners, special cases
        read_cell(15'd0, 0);
        read_cell(15'h7FFF, 0);
        send_beat(CMD_DEPOSIT, pos_for(0, 0), pos_for(1, 0), pos_for(2, 0),
                  32'sh7FFFFFFF, 32'sh80000000, 1, 32'sh7FFFFFFF, 1, 0, 0);
        send_beat(CMD_DEPOSIT, pos_for(0, 0), pos_for(1, 0), pos_for(2, 0),
                  32'sh7FFFFFFF, 32'sh80000000, -1, 32'sh80000000, 1, 0, 0);
        send_beat(CMD_DEPOSIT, pos_for(0, 0), pos_for(1, 0), pos_for(2, 0),
                  32'sh80000000, 32'sh80000000, 0, 32'sh80000000, 1, 0, 0);
        send_beat(CMD_DEPOSIT, pos_for(0, 31), pos_for(1, 31), pos_for(2, 31),
                  65536, -65536, 3, 0, -1, 0, 0);
        send_beat(CMD_DEPOSIT, pos_for(0, 31), pos_for(1, 31), pos_for(2, 31),
                  65536, -65536, 3, 65536, 0, 0, 0);
        send_beat(CMD_DEPOSIT, pos_for(0, 32), pos_for(1, 0), pos_for(2, 0),
                  1, 1, 1, 1, 0, 0, 0);
        send_beat(CMD_DEPOSIT, g_lo[0] - 1, pos_for(1, 0), pos_for(2, 0),
                  1, 1, 1, 1, 1, 0, 0);
        send_beat(CMD_DEPOSIT, 32'sh80000000, 32'sh7FFFFFFF, 0, 1, 1, 1, 1, 1, 0, 0);
        read_cell(15'd0, 0);
        read_cell(15'h7FFF, 0);
        drain();

        // phase: fine grid, full scale
        write_reg(CFG_X_LOW, 32'sh80000000);
        write_reg(CFG_Y_LOW, 32'sh80000000);
        write_reg(CFG_Z_LOW, 32'sh80000000);
        write_reg(CFG_X_SCALE, 32'hFFFFFF);
        write_reg(CFG_Y_SCALE, 32'hFFFFFF);
        write_reg(CFG_Z_SCALE, 32'hFFFFFF);
        write_reg(t_cfg_idx'(6), 32'h1234);
        random_phase(60, 3);

        // long output stall while beats keep coming
        hold_off = 1;
        for (int i = 0; i < 12; i++) read_cell(15'(i), 1);
        drain();

        // phase: zero x scale and unit y scale put these beats in cell zero of each axis
        write_reg(CFG_X_LOW, 32'sh7FFFFFFF);
        write_reg(CFG_X_SCALE, 0);
        write_reg(CFG_Y_SCALE, 1);
        send_beat(CMD_DEPOSIT, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000,
                  5, 5, 5, 7, 3, 0, 0);
        send_beat(CMD_DEPOSIT, 32'sh7FFFFFFE, 32'sh80000000, 32'sh80000000,
                  5, 5, 5, 7, 3, 0, 0);
        read_cell(15'd0, 0);
        drain();

        // phase: random grids, the first with its beats on a few cells only
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(CFG_X_LOW, $urandom);
            write_reg(CFG_Y_LOW, $urandom);
            write_reg(CFG_Z_LOW, $urandom);
            write_reg(CFG_X_SCALE, $urandom_range(1, 24'hFFFFFF));
            write_reg(CFG_Y_SCALE, $urandom_range(1, 24'hFFFFFF));
            write_reg(CFG_Z_SCALE, $urandom_range(1, 24'hFFFFFF));
            random_phase(85, ph == 0 ? 1 : 31);
            drain();
        end

        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // time limit covering the clearing sweep, every beat and the output stalls
    initial begin
        #20ms;
        $display("Mismatches found");
        $finish;
    end

endmodule
